>>> rtl/bole_pkg.sv
// Shared widths, operation codes and status codes of the ordered list engine.
`timescale 1ns / 1ps

package bole_pkg;

  // Field widths of the item and result beats.
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // Default list capacity.
  localparam int DEPTH_DEFAULT = 64;

  // Operation codes carried by the mode field.
  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP_FIRST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_LAST  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LIST      = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage

>>> rtl/bounded_ordered_list_engine_core.sv
// Top level of the ordered list engine: ring buffer in RAM walked by a small sequencer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------------
//   in      | input     | in_valid / in_stall | mode, value
//   out     | output    | out_valid/out_stall | status, position, entry_value, entry_count,
//           |           |                     | last_result
//
// One item is worked at a time; in_stall is high while an item is in progress.
// Insert and any empty or full case go straight to the result; remove first or last reads one entry.
// Search and listing walk the entries, one RAM read per cycle, a listing only while not stalled.
// Remove by value: tail, head, a scan, then a shift of the remaining entries, one per cycle.
// Reset empties the list at once; stored data needs no clearing pass.
// A stalled result beat holds the list walk; other items wait only to hand over the result.
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core import bole_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [CW-1:0]            position,
  output logic signed [DATA_W-1:0] entry_value,
  output logic [CW-1:0]            entry_count,
  output logic                     last_result
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  // Phases of remove by value.
  localparam logic [1:0] PH_TAIL = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_SCAN = 2'd2;

  localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(DEPTH);

  // Wrapping step of a ring slot.
  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    slot_dec = (s == '0) ? AW'(DEPTH - 1) : s - 1'b1;
  endfunction

  logic [1:0]          state, state_next;
  logic [1:0]          phase, phase_next;
  logic [MODE_W-1:0]   op, op_next;
  logic [DATA_W-1:0]   key, key_next;
  logic [AW-1:0]       fp, fp_next;
  logic [CW-1:0]       total, total_next;
  logic [CW-1:0]       rd_idx, rd_idx_next;
  logic [CW-1:0]       rd_end, rd_end_next;
  logic [AW-1:0]       rd_slot, rd_slot_next;
  logic                pend, pend_next;
  logic [CW-1:0]       pend_idx, pend_idx_next;
  logic [AW-1:0]       pend_slot, pend_slot_next;
  logic [AW-1:0]       wr_slot, wr_slot_next;
  logic [STATUS_W-1:0] em_status, em_status_next;
  logic [CW-1:0]       em_pos, em_pos_next;
  logic [DATA_W-1:0]   em_val, em_val_next;

  logic                out_valid_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic [CW-1:0]       out_pos, out_pos_next;
  logic [DATA_W-1:0]   out_val, out_val_next;
  logic [CW-1:0]       out_count, out_count_next;
  logic                out_last, out_last_next;

  logic                ram_we;
  logic [AW-1:0]       ram_wa;
  logic [DATA_W-1:0]   ram_wd;
  logic                ram_re;
  logic [DATA_W-1:0]   rd_data;

  logic                accept;
  logic                out_can;
  logic                rd_go;
  logic                consume;
  logic                issue;
  logic                match;
  logic                at_last;
  logic [CW-1:0]       cnt_m1;
  logic [AW:0]         tail_sum;
  logic [AW-1:0]       tail_slot;
  logic [CW-1:0]       pend_pos;

  // Entry storage.
  bole_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (rd_slot),
    .rd_data (rd_data)
  );

  // Slot of the last entry: front pointer plus count minus one, wrapped once.
  always_comb begin
    cnt_m1   = total - CW'(1);
    tail_sum = (AW + 1)'(fp) + (AW + 1)'(cnt_m1[AW-1:0]);
    if (tail_sum >= DEPTH_EXT) begin
      tail_slot = AW'(tail_sum - DEPTH_EXT);
    end else begin
      tail_slot = tail_sum[AW-1:0];
    end
  end

  // Read pipeline control and handshake terms.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_can  = !out_valid || !out_stall;
  assign rd_go    = (rd_idx != rd_end);
  assign consume  = pend && ((state == S_SHIFT) ||
                    ((state == S_WALK) && ((op != MODE_LIST) || out_can)));
  assign issue    = rd_go && ((state == S_SHIFT) || ((state == S_WALK) && (!pend || consume)));
  assign match    = (rd_data == key);
  assign pend_pos = pend_idx + CW'(1);
  assign at_last  = (pend_pos == total);

  // Sequencer next-state logic.
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    op_next        = op;
    key_next       = key;
    fp_next        = fp;
    total_next     = total;
    rd_idx_next    = rd_idx;
    rd_end_next    = rd_end;
    rd_slot_next   = rd_slot;
    pend_idx_next  = pend_idx;
    pend_slot_next = pend_slot;
    wr_slot_next   = wr_slot;
    em_status_next = em_status;
    em_pos_next    = em_pos;
    em_val_next    = em_val;
    ram_we         = 1'b0;
    ram_wa         = wr_slot;
    ram_wd         = rd_data;
    ram_re         = 1'b0;

    out_valid_next  = out_valid && out_stall;
    out_status_next = out_status;
    out_pos_next    = out_pos;
    out_val_next    = out_val;
    out_count_next  = out_count;
    out_last_next   = out_last;

    // Advance the read walk by one entry.
    if (issue) begin
      ram_re         = 1'b1;
      rd_idx_next    = rd_idx + CW'(1);
      rd_slot_next   = slot_inc(rd_slot);
      pend_idx_next  = rd_idx;
      pend_slot_next = rd_slot;
    end
    pend_next = issue ? 1'b1 : (consume ? 1'b0 : pend);

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next        = mode;
          key_next       = value;
          em_val_next    = value;
          em_status_next = ST_DONE;
          em_pos_next    = CW'(1);
          phase_next     = PH_TAIL;
          case (mode)
            MODE_INSERT: begin
              state_next = S_EMIT;
              if (total == CW'(DEPTH)) begin
                em_status_next = ST_FULL;
                em_pos_next    = '0;
              end else begin
                ram_we     = 1'b1;
                ram_wa     = slot_dec(fp);
                ram_wd     = value;
                fp_next    = slot_dec(fp);
                total_next = total + CW'(1);
              end
            end
            MODE_POP_FIRST, MODE_POP_LAST, MODE_REMOVE, MODE_SEARCH, MODE_LIST: begin
              if (total == '0) begin
                em_status_next = ST_EMPTY;
                em_pos_next    = '0;
                state_next     = S_EMIT;
              end else begin
                state_next = S_WALK;
                if ((mode == MODE_POP_LAST) || (mode == MODE_REMOVE)) begin
                  rd_idx_next  = cnt_m1;
                  rd_end_next  = total;
                  rd_slot_next = tail_slot;
                end else if (mode == MODE_POP_FIRST) begin
                  rd_idx_next  = '0;
                  rd_end_next  = CW'(1);
                  rd_slot_next = fp;
                end else begin
                  rd_idx_next  = '0;
                  rd_end_next  = total;
                  rd_slot_next = fp;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        if (consume) begin
          case (op)
            MODE_LIST: begin
              out_valid_next  = 1'b1;
              out_status_next = ST_DONE;
              out_pos_next    = pend_pos;
              out_val_next    = rd_data;
              out_count_next  = total;
              out_last_next   = at_last;
              if (at_last) begin
                state_next = S_IDLE;
              end
            end
            MODE_SEARCH: begin
              if (match) begin
                em_pos_next = pend_pos;
                state_next  = S_EMIT;
              end else if (at_last) begin
                em_status_next = ST_NOTFOUND;
                em_pos_next    = '0;
                state_next     = S_EMIT;
              end
            end
            MODE_POP_FIRST: begin
              em_val_next = rd_data;
              fp_next     = slot_inc(fp);
              total_next  = total - CW'(1);
              state_next  = S_EMIT;
            end
            MODE_POP_LAST: begin
              em_val_next = rd_data;
              em_pos_next = total;
              total_next  = total - CW'(1);
              state_next  = S_EMIT;
            end
            MODE_REMOVE: begin
              case (phase)
                PH_TAIL: begin
                  if (match) begin
                    em_pos_next = total;
                    total_next  = total - CW'(1);
                    state_next  = S_EMIT;
                  end else begin
                    phase_next   = PH_HEAD;
                    rd_idx_next  = '0;
                    rd_end_next  = CW'(1);
                    rd_slot_next = fp;
                  end
                end
                PH_HEAD: begin
                  if (match) begin
                    fp_next    = slot_inc(fp);
                    total_next = total - CW'(1);
                    state_next = S_EMIT;
                  end else if (total > CW'(1)) begin
                    phase_next   = PH_SCAN;
                    rd_idx_next  = CW'(1);
                    rd_end_next  = total;
                    rd_slot_next = slot_inc(fp);
                  end else begin
                    em_status_next = ST_NOTFOUND;
                    em_pos_next    = '0;
                    state_next     = S_EMIT;
                  end
                end
                default: begin
                  if (match) begin
                    // Close the gap: entries after the match move down by one.
                    em_pos_next  = pend_pos;
                    wr_slot_next = pend_slot;
                    rd_idx_next  = pend_pos;
                    rd_end_next  = total;
                    rd_slot_next = slot_inc(pend_slot);
                    state_next   = S_SHIFT;
                  end else if (at_last) begin
                    em_status_next = ST_NOTFOUND;
                    em_pos_next    = '0;
                    state_next     = S_EMIT;
                  end
                end
              endcase
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Each read entry is written one slot toward the front.
        if (pend) begin
          ram_we       = 1'b1;
          ram_wa       = wr_slot;
          ram_wd       = rd_data;
          wr_slot_next = slot_inc(wr_slot);
        end
        if (!rd_go && !pend) begin
          total_next = total - CW'(1);
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_can) begin
          out_valid_next  = 1'b1;
          out_status_next = em_status;
          out_pos_next    = em_pos;
          out_val_next    = em_val;
          out_count_next  = total;
          out_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A read left in flight when the walk ends is dropped.
    if (state_next != state) begin
      pend_next = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fp        <= '0;
      total     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fp        <= fp_next;
      total     <= total_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    phase      <= phase_next;
    op         <= op_next;
    key        <= key_next;
    rd_idx     <= rd_idx_next;
    rd_end     <= rd_end_next;
    rd_slot    <= rd_slot_next;
    pend_idx   <= pend_idx_next;
    pend_slot  <= pend_slot_next;
    wr_slot    <= wr_slot_next;
    em_status  <= em_status_next;
    em_pos     <= em_pos_next;
    em_val     <= em_val_next;
    out_status <= out_status_next;
    out_pos    <= out_pos_next;
    out_val    <= out_val_next;
    out_count  <= out_count_next;
    out_last   <= out_last_next;
  end

  // Result beat ports.
  assign status      = out_status;
  assign position    = out_pos;
  assign entry_value = out_val;
  assign entry_count = out_count;
  assign last_result = out_last;

endmodule

>>> rtl/bole_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bole_chk.sv
// Port-level checker of the ordered list engine, bound to the top level.
`timescale 1ns / 1ps

module bole_chk import bole_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [MODE_W-1:0]        mode,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [STATUS_W-1:0]      status,
  input logic [CW-1:0]            position,
  input logic signed [DATA_W-1:0] entry_value,
  input logic [CW-1:0]            entry_count,
  input logic                     last_result
);

  // A valid operation keeps the engine busy in the following cycle.
  a_busy_after_op: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode <= MODE_LIST) |=> in_stall)
    else $error("engine took a new beat right after a valid operation");

  // A full result reports a full list and no position.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (position == '0) && (entry_count == CW'(DEPTH)))
    else $error("full status with wrong position or count");

  // Any failing status is a single, final beat without a position.
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> last_result && (position == '0))
    else $error("failing status not a single final beat");

  // An empty result reports zero entries.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with nonzero count");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_value) && $stable(position))
    else $error("stalled result beat changed");

endmodule

bind bounded_ordered_list_engine_core bole_chk #(.DEPTH(DEPTH)) u_bole_chk (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the ordered list engine: directed and random list operations.
`timescale 1ns / 1ps

module tb_top;
  import bole_pkg::*;

  localparam int LIST_DEPTH    = DEPTH_DEFAULT;
  localparam int CNT_W         = $clog2(DEPTH_DEFAULT + 1);
  localparam int RANDOM_ITEMS  = 25;
  localparam int QUIET_ITEMS   = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 1000000;

  // Mode codes the block must ignore.
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] entry_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     last_result;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [MODE_W-1:0]        mode = MODE_INSERT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] entry_value;
  logic [CNT_W-1:0]         entry_count;
  logic                     last_result;

  // Expected list contents, front at index 0, and the result beats still owed.
  logic signed [DATA_W-1:0] shadow_list[$];
  list_result_t             pending_results[$];

  int   error_count  = 0;
  int   cycle_count  = 0;
  logic idle_on      = 1'b0;
  logic hold_request = 1'b0;

  bounded_ordered_list_engine_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .position    (position),
    .entry_value (entry_value),
    .entry_count (entry_count),
    .last_result (last_result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Record one expected result beat; the count is taken after the list update.
  function automatic void queue_result(input logic [STATUS_W-1:0] st, input int pos,
                                       input logic signed [DATA_W-1:0] val,
                                       input logic last);
    list_result_t r;
    r.status      = st;
    r.position    = CNT_W'(pos);
    r.entry_value = val;
    r.entry_count = CNT_W'(shadow_list.size());
    r.last_result = last;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted operation to the shadow list and queue its results.
  task automatic apply_list_op(input logic [MODE_W-1:0] op,
                               input logic signed [DATA_W-1:0] operand);
    int                       n;
    int                       found;
    logic signed [DATA_W-1:0] taken;
    n     = shadow_list.size();
    found = -1;
    if (op == MODE_INSERT) begin
      if (n >= LIST_DEPTH) begin
        queue_result(ST_FULL, 0, operand, 1'b1);
      end else begin
        shadow_list.push_front(operand);
        queue_result(ST_DONE, 1, operand, 1'b1);
      end
    end else if (op > MODE_LIST) begin
      // Unused codes leave the list alone and produce nothing.
    end else if (n == 0) begin
      queue_result(ST_EMPTY, 0, operand, 1'b1);
    end else begin
      case (op)
        MODE_POP_FIRST: begin
          taken = shadow_list.pop_front();
          queue_result(ST_DONE, 1, taken, 1'b1);
        end
        MODE_POP_LAST: begin
          taken = shadow_list.pop_back();
          queue_result(ST_DONE, n, taken, 1'b1);
        end
        MODE_REMOVE: begin
          // The tail is tried first, then the head, then a scan from the second entry.
          if (shadow_list[n-1] == operand) begin
            taken = shadow_list.pop_back();
            queue_result(ST_DONE, n, operand, 1'b1);
          end else if (shadow_list[0] == operand) begin
            taken = shadow_list.pop_front();
            queue_result(ST_DONE, 1, operand, 1'b1);
          end else begin
            for (int i = 1; i < n; i++) begin
              if (found < 0 && shadow_list[i] == operand) found = i;
            end
            if (found >= 0) begin
              shadow_list.delete(found);
              queue_result(ST_DONE, found + 1, operand, 1'b1);
            end else begin
              queue_result(ST_NOTFOUND, 0, operand, 1'b1);
            end
          end
        end
        MODE_SEARCH: begin
          for (int i = 0; i < n; i++) begin
            if (found < 0 && shadow_list[i] == operand) found = i;
          end
          if (found >= 0) queue_result(ST_DONE, found + 1, operand, 1'b1);
          else queue_result(ST_NOTFOUND, 0, operand, 1'b1);
        end
        default: begin
          for (int i = 0; i < n; i++) queue_result(ST_DONE, i + 1, shadow_list[i], i == n - 1);
        end
      endcase
    end
  endtask

  // Offer one item beat, hold it until taken, then update the prediction.
  task automatic send_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] operand);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    value    <= operand;
    // Stall is stable at the falling edge; the next rising edge takes the beat.
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    apply_list_op(op, operand);
  endtask

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    int grow;
    r    = $urandom_range(0, 99);
    grow = (shadow_list.size() >= 48) ? 12 : 40;
    if (r < grow) return MODE_INSERT;
    r = $urandom_range(0, 99);
    if (r < 15) return MODE_POP_FIRST;
    if (r < 30) return MODE_POP_LAST;
    if (r < 60) return MODE_REMOVE;
    if (r < 82) return MODE_SEARCH;
    if (r < 94) return MODE_LIST;
    return $urandom_range(0, 1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
  endfunction

  // Mostly small or already stored values, so that matches and duplicates are common.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return int'($urandom_range(0, 6)) - 3;
    if (r < 65 && shadow_list.size() != 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (r < 75) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    return $urandom;
  endfunction

  // Empty-list cases, unused codes, extreme values and each removal path.
  task automatic test_directed_ops();
    send_op(MODE_POP_FIRST, VAL_MIN);
    send_op(MODE_POP_LAST, VAL_MAX);
    send_op(MODE_REMOVE, 0);
    send_op(MODE_SEARCH, -1);
    send_op(MODE_LIST, 1);
    send_op(MODE_UNUSED_6, 5);
    send_op(MODE_UNUSED_7, -5);
    send_op(MODE_INSERT, VAL_MAX);
    send_op(MODE_INSERT, VAL_MIN);
    send_op(MODE_INSERT, 0);
    send_op(MODE_INSERT, -1);
    send_op(MODE_SEARCH, VAL_MIN);
    send_op(MODE_SEARCH, 5);
    send_op(MODE_LIST, 0);
    // A value at the head and deeper in the list goes from the head.
    send_op(MODE_INSERT, VAL_MIN);
    send_op(MODE_REMOVE, VAL_MIN);
    // A value at the head and the tail goes from the tail.
    send_op(MODE_INSERT, VAL_MAX);
    send_op(MODE_REMOVE, VAL_MAX);
    send_op(MODE_REMOVE, 0);
    send_op(MODE_REMOVE, 12345);
    send_op(MODE_POP_FIRST, 0);
    send_op(MODE_POP_LAST, 0);
    send_op(MODE_REMOVE, -1);
  endtask

  // Fill to capacity, overflow, then walk the full list under a long output hold.
  task automatic test_full_list();
    while (shadow_list.size() < LIST_DEPTH) send_op(MODE_INSERT, $urandom);
    send_op(MODE_INSERT, VAL_MAX);
    send_op(MODE_INSERT, VAL_MIN);
    hold_request = 1'b1;
    send_op(MODE_LIST, 0);
    send_op(MODE_SEARCH, shadow_list[LIST_DEPTH-1]);
    send_op(MODE_SEARCH, $urandom);
    send_op(MODE_REMOVE, shadow_list[1]);
    send_op(MODE_INSERT, VAL_MIN);
    send_op(MODE_LIST, 0);
  endtask

  // Random operation mix; ignored codes do not count toward the total.
  task automatic test_random_ops(input int count);
    int                       sent;
    logic [MODE_W-1:0]        op;
    sent = 0;
    while (sent < count) begin
      op = pick_mode();
      send_op(op, pick_value());
      if (op <= MODE_LIST) sent++;
    end
  endtask

  // Output back-pressure: short random bursts, or one long hold on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        @(posedge clk) out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        @(posedge clk) out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Compare each result beat that the next rising edge will take.
  always @(negedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing outstanding, status %h position %0d value %h",
                 $time, status, position, entry_value);
      end else begin
        want = pending_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(status));
        check_field("position", DATA_W'(want.position), DATA_W'(position));
        check_field("entry_value", want.entry_value, entry_value);
        check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(entry_count));
        check_field("last_result", DATA_W'(want.last_result), DATA_W'(last_result));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    test_directed_ops();
    test_full_list();
    test_random_ops(RANDOM_ITEMS);
    // Closing stretch with no idling on either side.
    idle_on = 1'b0;
    test_random_ops(QUIET_ITEMS);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
